### hw/rtl/mse_pkg.sv
package mse_pkg;

  localparam int DMEM_WORDS = 1024;  // power of two
  localparam int DMEM_AW    = $clog2(DMEM_WORDS);

  localparam logic [31:0] PC_RESET = 32'h0040_0000;

  // opcodes
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_BGTZ  = 6'd7;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  // R-type funct codes
  localparam logic [5:0] FN_SYSCALL = 6'd12;
  localparam logic [5:0] FN_ADD     = 6'd32;
  localparam logic [5:0] FN_ADDU    = 6'd33;
  localparam logic [5:0] FN_SUB     = 6'd34;
  localparam logic [5:0] FN_SUBU    = 6'd35;
  localparam logic [5:0] FN_AND     = 6'd36;

  // syscall service codes in v0
  localparam logic [31:0] SYS_PRINT_INT = 32'd1;
  localparam logic [31:0] SYS_EXIT      = 32'd10;

  localparam logic [4:0] REG_V0 = 5'd2;
  localparam logic [4:0] REG_A0 = 5'd4;

  typedef struct packed {
    logic [31:0]        next_pc;
    logic               reg_write;
    logic [4:0]         reg_index;
    logic [31:0]        reg_value;
    logic               mem_write;
    logic [31:0]        mem_address;
    logic [31:0]        mem_data;
    logic               halted;
    logic               print_valid;
    logic signed [31:0] print_value;
  } result_t;

endpackage

### hw/rtl/mips_subset_execute_step.sv
// Channel  Direction  Handshake            Payload
// in_      input      in_valid/in_ready    in_instruction_word
// out_     output     out_valid/out_ready  next_pc, reg/mem writes, halted, print
// cfg_     input      cfg_we (no wait)     cfg_wdata -> program counter
//
// An item is decoded and executed in the execute register stage, then lands in
// the result register, which drives out_valid. A new item can be taken every
// cycle while the output is not stalled and no lw holds the execute stage.
// lw holds the execute stage for the registered data memory read.
// After reset the data memory is cleared, one word per cycle, over all DMEM_WORDS
// words; in_ready stays low meanwhile. A stalled output holds the execute stage.
module mips_subset_execute_step import mse_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_instruction_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_next_pc,
  output logic               out_reg_write,
  output logic [4:0]         out_reg_index,
  output logic [31:0]        out_reg_value,
  output logic               out_mem_write,
  output logic [31:0]        out_mem_address,
  output logic [31:0]        out_mem_data,
  output logic               out_halted,
  output logic               out_print_valid,
  output logic signed [31:0] out_print_value
);

  // control
  logic               clr_busy_r;
  logic [DMEM_AW-1:0] clr_cnt_r;
  logic               ex_valid_r;
  logic               ld_phase_r;
  logic               stopped_r;
  logic               out_valid_r;
  logic [31:0]        pc_r;

  // execute stage payload
  logic [31:0]        ex_iw_r;
  logic [31:0]        rs_raw_r, rt_raw_r;
  logic               rs_ok_r, rt_ok_r;
  logic               rs_fwd_r, rt_fwd_r;
  logic [31:0]        fwd_val_r;
  logic [31:0]        v0_r, a0_r;
  logic [31:0]        dmem_rd_r;
  result_t            out_r;

  // storage
  logic [31:0]        rf_mem [32];
  logic [31:0]        rf_vld_r;
  logic [31:0]        dmem [DMEM_WORDS];

  logic               in_acc, ex_done, ld_issue, halt_now;
  logic [4:0]         in_rs, in_rt;
  logic [5:0]         op, funct;
  logic [31:0]        imm, seq, rs_val, rt_val, addr_sum;
  logic               rf_we;
  logic               dm_we;
  logic [DMEM_AW-1:0] dm_widx;
  logic [31:0]        dm_wdata;
  result_t            res;

  assign in_rs = in_instruction_word[25:21];
  assign in_rt = in_instruction_word[20:16];

  assign op       = ex_iw_r[31:26];
  assign funct    = ex_iw_r[5:0];
  assign imm      = {{16{ex_iw_r[15]}}, ex_iw_r[15:0]};
  assign seq      = pc_r + 32'd4;
  assign rs_val   = rs_fwd_r ? fwd_val_r : (rs_ok_r ? rs_raw_r : 32'd0);
  assign rt_val   = rt_fwd_r ? fwd_val_r : (rt_ok_r ? rt_raw_r : 32'd0);
  assign addr_sum = rs_val + imm;

  assign ld_issue = ex_valid_r && !stopped_r && (op == OP_LW) && !ld_phase_r;
  assign ex_done  = ex_valid_r && !ld_issue && (!out_valid_r || out_ready);
  assign in_ready = !clr_busy_r && (!ex_valid_r || ex_done);
  assign in_acc   = in_valid && in_ready;

  // execute
  always_comb begin
    res             = '0;
    res.next_pc     = seq;
    halt_now        = 1'b0;
    if (stopped_r) begin
      res.next_pc = pc_r;
    end else begin
      unique case (op) inside
        OP_RTYPE: begin
          unique case (funct) inside
            FN_ADD, FN_ADDU: begin
              res.reg_write = 1'b1;
              res.reg_index = ex_iw_r[15:11];
              res.reg_value = rs_val + rt_val;
            end
            FN_SUB, FN_SUBU: begin
              res.reg_write = 1'b1;
              res.reg_index = ex_iw_r[15:11];
              res.reg_value = rs_val - rt_val;
            end
            FN_AND: begin
              res.reg_write = 1'b1;
              res.reg_index = ex_iw_r[15:11];
              res.reg_value = rs_val & rt_val;
            end
            FN_SYSCALL: begin
              if (v0_r == SYS_EXIT) begin
                halt_now = 1'b1;
              end else if (v0_r == SYS_PRINT_INT) begin
                res.print_valid = 1'b1;
                res.print_value = a0_r;
              end
            end
            default: ;
          endcase
        end
        OP_ADDI, OP_ADDIU: begin
          res.reg_write = 1'b1;
          res.reg_index = ex_iw_r[20:16];
          res.reg_value = addr_sum;
        end
        OP_LW: begin
          res.mem_address = addr_sum;
          res.reg_write   = 1'b1;
          res.reg_index   = ex_iw_r[20:16];
          res.reg_value   = dmem_rd_r;
        end
        OP_SW: begin
          res.mem_address = addr_sum;
          res.mem_write   = 1'b1;
          res.mem_data    = rt_val;
        end
        OP_BGTZ: begin
          if (rs_val != 32'd0 && !rs_val[31]) begin
            res.next_pc = seq + {imm[29:0], 2'b00};
          end
        end
        OP_J: begin
          res.next_pc = {seq[31:28], ex_iw_r[25:0], 2'b00};
        end
        default: ;
      endcase
      // r0 is hardwired
      if (res.reg_index == 5'd0) begin
        res.reg_write = 1'b0;
        res.reg_value = '0;
      end
    end
    res.halted = stopped_r || halt_now;
  end

  assign rf_we = ex_done && res.reg_write;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      ex_valid_r  <= 1'b0;
      ld_phase_r  <= 1'b0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= PC_RESET;
      rf_vld_r    <= '0;
      v0_r        <= '0;
      a0_r        <= '0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == DMEM_AW'(DMEM_WORDS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (in_acc) begin
        ex_valid_r <= 1'b1;
      end else if (ex_done) begin
        ex_valid_r <= 1'b0;
      end
      if (ld_issue) begin
        ld_phase_r <= 1'b1;
      end else if (ex_done) begin
        ld_phase_r <= 1'b0;
      end
      if (ex_done) begin
        out_valid_r <= 1'b1;
        pc_r        <= res.next_pc;
        if (halt_now) begin
          stopped_r <= 1'b1;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        pc_r <= cfg_wdata;
      end
      if (rf_we) begin
        rf_vld_r[res.reg_index] <= 1'b1;
        if (res.reg_index == REG_V0) begin
          v0_r <= res.reg_value;
        end
        if (res.reg_index == REG_A0) begin
          a0_r <= res.reg_value;
        end
      end
    end
  end

  // execute stage payload and register file read, with write forwarding
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ex_iw_r   <= in_instruction_word;
      rs_raw_r  <= rf_mem[in_rs];
      rt_raw_r  <= rf_mem[in_rt];
      rs_ok_r   <= rf_vld_r[in_rs];
      rt_ok_r   <= rf_vld_r[in_rt];
      rs_fwd_r  <= rf_we && (res.reg_index == in_rs);
      rt_fwd_r  <= rf_we && (res.reg_index == in_rt);
      fwd_val_r <= res.reg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[res.reg_index] <= res.reg_value;
    end
  end

  // data memory: clearing pass after reset, then sw writes; word index wraps
  assign dm_we    = clr_busy_r || (ex_done && res.mem_write);
  assign dm_widx  = clr_busy_r ? clr_cnt_r : res.mem_address[DMEM_AW+1:2];
  assign dm_wdata = clr_busy_r ? 32'd0 : res.mem_data;

  always_ff @(posedge clk) begin
    if (dm_we) begin
      dmem[dm_widx] <= dm_wdata;
    end
    if (ld_issue) begin
      dmem_rd_r <= dmem[addr_sum[DMEM_AW+1:2]];
    end
  end

  always_ff @(posedge clk) begin
    if (ex_done) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_r.next_pc;
  assign out_reg_write   = out_r.reg_write;
  assign out_reg_index   = out_r.reg_index;
  assign out_reg_value   = out_r.reg_value;
  assign out_mem_write   = out_r.mem_write;
  assign out_mem_address = out_r.mem_address;
  assign out_mem_data    = out_r.mem_data;
  assign out_halted      = out_r.halted;
  assign out_print_valid = out_r.print_valid;
  assign out_print_value = out_r.print_value;

endmodule
